### hdl/scsg_pkg.sv
// ---------------------------------------------------------------------------
// scsg_pkg: shared types and constants of the staircase current step generator
// Holds the phase encoding, the register indexes and the fixed output widths.
// ---------------------------------------------------------------------------
package scsg_pkg;

	localparam int OUT_W = 20;
	localparam int NUM_W = 8;
	localparam int REG_IDX_W = 3;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sh7FFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 20'sh80000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DELAY_TICKS    = 3'd0,
		REG_PULSE_TICKS    = 3'd1,
		REG_PAUSE_TICKS    = 3'd2,
		REG_START_CURRENT  = 3'd3,
		REG_STEP_CURRENT   = 3'd4,
		REG_OFFSET_CURRENT = 3'd5,
		REG_STEP_COUNT     = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_DELAY = 4'b0001,
		PH_PULSE = 4'b0010,
		PH_PAUSE = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

endpackage

### hdl/scsg_if.sv
// ---------------------------------------------------------------------------
// scsg interfaces: tick, result and configuration channels
// Each channel carries valid, ready and its payload, with source and sink views.
// ---------------------------------------------------------------------------
interface scsg_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface scsg_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [scsg_pkg::OUT_W-1:0]    drive_current;
	logic        [scsg_pkg::NUM_W-1:0]    step_number;
	logic                                 in_pulse;
	logic                                 sequence_done;

	modport source (output valid, output drive_current, output step_number,
		output in_pulse, output sequence_done, input ready);
	modport sink (input valid, input drive_current, input step_number,
		input in_pulse, input sequence_done, output ready);
endinterface

interface scsg_cfg_if #(
	parameter int DATA_W = 32
);
	logic                              valid;
	logic                              ready;
	logic [scsg_pkg::REG_IDX_W-1:0]    index;
	logic [DATA_W-1:0]                 data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/staircase_current_step_generator.sv
// ---------------------------------------------------------------------------
// staircase_current_step_generator: staircase current stimulus sequencer
// Each tick item advances the delay, pulse and pause sequence by one sample
// and yields one result item with the commanded current and step status.
//
// Channels: tick (restart flag), result (drive_current, step_number,
// in_pulse, sequence_done) and cfg (register index and write data, always
// ready). The cfg data width must cover TICK_WIDTH and CURRENT_WIDTH.
// One tick item can be accepted every cycle while the result receiver is
// ready. The sequence state and the first-stage fields are registered on
// acceptance; the level multiply, sum and saturation are then registered
// into the result register, which holds its item while the receiver stalls;
// one more tick item may still fill the first stage, then tick.ready drops.
// Reset loads the register defaults and puts the sequence at the start of
// the delay with no items in flight.
// ---------------------------------------------------------------------------
module staircase_current_step_generator #(
	parameter int TICK_WIDTH    = 32,
	parameter int CURRENT_WIDTH = 18
) (
	input  logic           clk,
	input  logic           arst_n,
	scsg_tick_if.sink      tick,
	scsg_result_if.source  result,
	scsg_cfg_if.sink       cfg
);

	localparam int CW    = CURRENT_WIDTH;
	localparam int PW    = CW + scsg_pkg::NUM_W + 1;
	localparam int SUM_W = CW + scsg_pkg::NUM_W + 3;
	localparam int EXT_W = (SUM_W > scsg_pkg::OUT_W) ? SUM_W : scsg_pkg::OUT_W;
	localparam int NW    = scsg_pkg::NUM_W;

	logic [TICK_WIDTH-1:0]  delay_ticks_q, pulse_ticks_q, pause_ticks_q;
	logic signed [CW-1:0]   start_current_q, step_current_q, offset_current_q;
	logic [NW-1:0]          step_count_q;

	scsg_pkg::phase_t       phase_q, ph_e, ph_n;
	logic [TICK_WIDTH-1:0]  ticks_q, ticks_e, ticks_n;
	logic [NW-1:0]          idx_q, idx_e, idx_n;
	logic                   enter;
	logic [NW:0]            k_next;

	logic                   valid_s1;
	logic                   pulse_s1, done_s1;
	logic [NW-1:0]          num_s1;

	logic                   valid_q;
	logic signed [scsg_pkg::OUT_W-1:0] drive_q;
	logic [NW-1:0]          num_q;
	logic                   pulse_q, done_q;

	logic                   adv2, tick_acc;
	logic [NW-1:0]          km1;
	logic signed [PW-1:0]   prod;
	logic signed [SUM_W-1:0] sum;
	logic signed [EXT_W-1:0] sum_x;
	logic signed [scsg_pkg::OUT_W-1:0] level;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q    <= '0;
			pulse_ticks_q    <= TICK_WIDTH'(1000);
			pause_ticks_q    <= TICK_WIDTH'(10000);
			start_current_q  <= CW'(10);
			step_current_q   <= CW'(10);
			offset_current_q <= '0;
			step_count_q     <= NW'(15);
		end else if (cfg.valid) begin
			case (cfg.index)
				scsg_pkg::REG_DELAY_TICKS:    delay_ticks_q    <= cfg.data[TICK_WIDTH-1:0];
				scsg_pkg::REG_PULSE_TICKS:    pulse_ticks_q    <= cfg.data[TICK_WIDTH-1:0];
				scsg_pkg::REG_PAUSE_TICKS:    pause_ticks_q    <= cfg.data[TICK_WIDTH-1:0];
				scsg_pkg::REG_START_CURRENT:  start_current_q  <= cfg.data[CW-1:0];
				scsg_pkg::REG_STEP_CURRENT:   step_current_q   <= cfg.data[CW-1:0];
				scsg_pkg::REG_OFFSET_CURRENT: offset_current_q <= cfg.data[CW-1:0];
				scsg_pkg::REG_STEP_COUNT:     step_count_q     <= cfg.data[NW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv2       = !valid_q || result.ready;
	assign tick.ready = !valid_s1 || adv2;
	assign tick_acc   = tick.valid && tick.ready;

	// A restart makes this tick the first tick of the delay.
	always_comb begin
		ph_e    = tick.restart ? scsg_pkg::PH_DELAY : phase_q;
		ticks_e = tick.restart ? '0 : ticks_q;
		idx_e   = tick.restart ? NW'(1) : idx_q;
	end

	always_comb begin
		ph_n    = ph_e;
		ticks_n = ticks_e + TICK_WIDTH'(1);
		idx_n   = idx_e;
		enter   = 1'b0;
		k_next  = {1'b0, idx_e} + (NW+1)'(1);
		case (ph_e)
			scsg_pkg::PH_DELAY: begin
				if (ticks_e >= delay_ticks_q) begin
					enter  = 1'b1;
					k_next = (NW+1)'(1);
				end
			end
			scsg_pkg::PH_PULSE: begin
				if (({1'b0, ticks_e} + (TICK_WIDTH+1)'(1)) >= {1'b0, pulse_ticks_q}) begin
					if (pause_ticks_q != '0) begin
						ph_n    = scsg_pkg::PH_PAUSE;
						ticks_n = '0;
					end else begin
						enter = 1'b1;
					end
				end
			end
			scsg_pkg::PH_PAUSE: begin
				if (({1'b0, ticks_e} + (TICK_WIDTH+1)'(1)) >= {1'b0, pause_ticks_q}) begin
					enter = 1'b1;
				end
			end
			default: begin
				ticks_n = ticks_e;
			end
		endcase
		if (enter) begin
			ticks_n = '0;
			if (k_next > {1'b0, step_count_q}) begin
				idx_n = step_count_q;
				ph_n  = scsg_pkg::PH_DONE;
			end else begin
				idx_n = k_next[NW-1:0];
				ph_n  = (pulse_ticks_q != '0) ? scsg_pkg::PH_PULSE : scsg_pkg::PH_PAUSE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= scsg_pkg::PH_DELAY;
			ticks_q  <= '0;
			idx_q    <= NW'(1);
			valid_s1 <= 1'b0;
		end else if (tick_acc) begin
			phase_q  <= ph_n;
			ticks_q  <= ticks_n;
			idx_q    <= idx_n;
			valid_s1 <= 1'b1;
		end else if (adv2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			pulse_s1 <= (ph_e == scsg_pkg::PH_PULSE);
			done_s1  <= (ph_e == scsg_pkg::PH_DONE);
			num_s1   <= (ph_e == scsg_pkg::PH_DELAY) ? '0 : idx_e;
		end
	end

	// Pulse k drives offset + start + (k-1)*step; every other phase the offset.
	assign km1   = num_s1 - NW'(1);
	assign prod  = $signed({1'b0, km1}) * step_current_q;
	assign sum   = SUM_W'(offset_current_q)
		+ (pulse_s1 ? (SUM_W'(start_current_q) + SUM_W'(prod)) : '0);
	assign sum_x = EXT_W'(sum);

	always_comb begin
		if (sum_x > EXT_W'(scsg_pkg::OUT_MAX)) begin
			level = scsg_pkg::OUT_MAX;
		end else if (sum_x < EXT_W'(scsg_pkg::OUT_MIN)) begin
			level = scsg_pkg::OUT_MIN;
		end else begin
			level = sum_x[scsg_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv2) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			drive_q <= level;
			num_q   <= num_s1;
			pulse_q <= pulse_s1;
			done_q  <= done_s1;
		end
	end

	assign result.valid         = valid_q;
	assign result.drive_current = drive_q;
	assign result.step_number   = num_q;
	assign result.in_pulse      = pulse_q;
	assign result.sequence_done = done_q;

endmodule

### hdl/scsg_checker.sv
// ---------------------------------------------------------------------------
// scsg_checker: port-level checks of the staircase current step generator
// Watches the result channel and the consistency of its status fields.
// ---------------------------------------------------------------------------
module scsg_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [scsg_pkg::OUT_W-1:0]   drive_current,
	input logic        [scsg_pkg::NUM_W-1:0]   step_number,
	input logic                                in_pulse,
	input logic                                sequence_done
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(drive_current) && $stable(step_number)
			&& $stable(in_pulse) && $stable(sequence_done))
		else $error("result item changed while stalled");

	a_pulse_numbered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_pulse |-> step_number != '0)
		else $error("pulse item without a pulse number");

	a_done_not_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sequence_done |-> !in_pulse)
		else $error("pulse item flagged as done");

endmodule

bind staircase_current_step_generator scsg_checker u_scsg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.drive_current (result.drive_current),
	.step_number   (result.step_number),
	.in_pulse      (result.in_pulse),
	.sequence_done (result.sequence_done)
);
